// ===== rtl/gptb_pkg.sv =====
// Shared types and constants for the general purpose timer bank.
`default_nettype none

package gptb_pkg;

	// Item command codes
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Global register words
	localparam logic [5:0] WORD_ENABLE  = 6'd32;
	localparam logic [5:0] WORD_DISABLE = 6'd33;
	localparam logic [5:0] WORD_STATUS  = 6'd34;

	// Register offsets inside one timer's four-word block
	localparam logic [1:0] REG_CONFIG = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;
	localparam logic [1:0] REG_WIDTH  = 2'd3;

	// Clock source codes
	localparam logic [1:0] SRC_SYSTEM = 2'd0;
	localparam logic [1:0] SRC_PIN    = 2'd1;
	localparam logic [1:0] SRC_TIMER  = 2'd2;

	// Config register bits
	localparam logic [7:0] CFG_WRITABLE = 8'hBF;
	localparam int CFG_PERIOD_CNT = 3;
	localparam int CFG_IRQ_ENA    = 4;
	localparam int CFG_TIN_SEL    = 5;
	localparam int CFG_CLK_SEL    = 7;

	// Error kind codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	// Status word layout: per group of four timers, 16 bits
	localparam int STATUS_GROUP = 16;
	localparam int STATUS_OVF   = 4;
	localparam int STATUS_RUN   = 12;

	// Per-channel control for one transaction
	typedef struct packed {
		logic        tick;
		logic [1:0]  src;
		logic        cfg_we;
		logic        period_we;
		logic        width_we;
		logic        enable_set;
		logic        disable_set;
		logic        halt;
		logic        ovf_clr;
		logic        pend_clr;
		logic [31:0] wdata;
	} gptb_ctl_t;

	// Per-channel state seen by the register file
	typedef struct packed {
		logic        enabled;
		logic        running;
		logic        overflow;
		logic        pending;
		logic [7:0]  cfg;
		logic [1:0]  err;
		logic [31:0] count;
		logic [31:0] period;
		logic [31:0] width;
	} gptb_stat_t;

endpackage

`default_nettype wire

// ===== rtl/gptb_chan.sv =====
// One timer channel: counter, buffered period/width, flags and tick handling.
`default_nettype none

module gptb_chan (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gptb_pkg::gptb_ctl_t  ctl,
	output gptb_pkg::gptb_stat_t      stat,
	output logic                      raise
);

	logic        enabled_q, running_q, overflow_q, pending_q;
	logic [7:0]  cfg_q;
	logic [1:0]  err_q, src_q;
	logic [31:0] count_q, period_q, width_q, pper_q, pwid_q;

	logic        enabled_n, running_n, overflow_n, pending_n;
	logic [7:0]  cfg_n;
	logic [1:0]  err_n, src_n;
	logic [31:0] count_n, period_n, width_n, pper_n, pwid_n;
	logic [31:0] count_inc;
	logic        irq_en;

	assign count_inc = count_q + 32'd1;
	assign irq_en    = cfg_q[gptb_pkg::CFG_IRQ_ENA];

	// Next-state for one transaction
	always_comb begin
		enabled_n  = enabled_q;
		running_n  = running_q;
		overflow_n = overflow_q;
		pending_n  = pending_q;
		cfg_n      = cfg_q;
		err_n      = err_q;
		src_n      = src_q;
		count_n    = count_q;
		period_n   = period_q;
		width_n    = width_q;
		pper_n     = pper_q;
		pwid_n     = pwid_q;
		raise      = 1'b0;

		// Register writes
		if (ctl.cfg_we) begin
			cfg_n = ctl.wdata[7:0] & gptb_pkg::CFG_WRITABLE;
		end
		if (ctl.period_we) begin
			pper_n = ctl.wdata;
		end
		if (ctl.width_we) begin
			pwid_n = ctl.wdata;
		end

		// Start on enable of a disabled timer
		if (ctl.enable_set) begin
			if (!enabled_q) begin
				count_n = cfg_q[gptb_pkg::CFG_CLK_SEL] ? 32'd0 : 32'd1;
				if (!cfg_q[gptb_pkg::CFG_CLK_SEL]) begin
					src_n = gptb_pkg::SRC_SYSTEM;
				end else if (!cfg_q[gptb_pkg::CFG_TIN_SEL]) begin
					src_n = gptb_pkg::SRC_PIN;
				end else begin
					src_n = gptb_pkg::SRC_TIMER;
				end
				period_n  = pper_q;
				width_n   = pwid_q;
				running_n = 1'b1;
			end
			enabled_n = 1'b1;
		end
		if (ctl.disable_set) begin
			enabled_n = 1'b0;
		end

		// Status register clears
		if (ctl.halt) begin
			running_n = 1'b0;
			period_n  = pper_q;
			width_n   = pwid_q;
		end
		if (ctl.ovf_clr) begin
			overflow_n = 1'b0;
			err_n      = gptb_pkg::ERR_NONE;
		end
		if (ctl.pend_clr) begin
			pending_n = 1'b0;
		end

		// Count on a matching tick
		if (ctl.tick && running_q && (ctl.src == src_q)) begin
			count_n = count_inc;
			if (count_inc == gptb_pkg::ALL_ONES) begin
				overflow_n = 1'b1;
				err_n      = gptb_pkg::ERR_OVERFLOW;
				raise      = irq_en;
			end
			if (cfg_q[gptb_pkg::CFG_PERIOD_CNT] && (count_inc == period_q)) begin
				pending_n = 1'b1;
				raise     = raise | irq_en;
				period_n  = pper_q;
				width_n   = pwid_q;
				running_n = enabled_q;
				if (enabled_q) begin
					count_n = 32'd0;
				end
			end else if (!cfg_q[gptb_pkg::CFG_PERIOD_CNT] && (count_inc == width_q)) begin
				pending_n = 1'b1;
				raise     = raise | irq_en;
				enabled_n = 1'b0;
				running_n = 1'b0;
				period_n  = pper_q;
				width_n   = pwid_q;
			end
		end
	end

	// Channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			running_q  <= 1'b0;
			overflow_q <= 1'b0;
			pending_q  <= 1'b0;
			cfg_q      <= '0;
			err_q      <= gptb_pkg::ERR_NONE;
			src_q      <= gptb_pkg::SRC_SYSTEM;
			count_q    <= 32'd1;
			period_q   <= '0;
			width_q    <= '0;
			pper_q     <= '0;
			pwid_q     <= '0;
		end else begin
			enabled_q  <= enabled_n;
			running_q  <= running_n;
			overflow_q <= overflow_n;
			pending_q  <= pending_n;
			cfg_q      <= cfg_n;
			err_q      <= err_n;
			src_q      <= src_n;
			count_q    <= count_n;
			period_q   <= period_n;
			width_q    <= width_n;
			pper_q     <= pper_n;
			pwid_q     <= pwid_n;
		end
	end

	assign stat.enabled  = enabled_q;
	assign stat.running  = running_q;
	assign stat.overflow = overflow_q;
	assign stat.pending  = pending_q;
	assign stat.cfg      = cfg_q;
	assign stat.err      = err_q;
	assign stat.count    = count_q;
	assign stat.period   = period_q;
	assign stat.width    = width_q;

endmodule

`default_nettype wire

// ===== rtl/general_purpose_timer_bank_core.sv =====
// Timer bank top level: input stage, register decode, channels, result stage.
// Pipeline: each accepted transaction goes from the input register to the
//   result register; all channels update in parallel at that same edge.
// Throughput: one transaction per cycle unless out_ready stalls the result.
// Reset: arst_n clears all flags, config and buffers, counters load 1,
//   clock sources return to system; both stages come up empty.
`default_nettype none

module general_purpose_timer_bank_core #(
	parameter int NUM_TIMERS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [5:0]  word_index,
	input  wire logic [31:0] write_data,
	input  wire logic [1:0]  tick_source,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      read_data,
	output logic [7:0]       irq_raise,
	output logic [7:0]       irq_lower
);

	logic        valid_s1, valid_s2;
	logic [1:0]  cmd_s1, src_s1;
	logic [5:0]  word_s1;
	logic [31:0] data_s1;
	logic [31:0] read_data_s2;
	logic [7:0]  irq_raise_s2, irq_lower_s2;

	logic adv, in_fire;
	logic is_read, is_write, is_tick;

	gptb_pkg::gptb_ctl_t  ctl  [NUM_TIMERS];
	gptb_pkg::gptb_stat_t stat [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] raise_vec;
	logic [NUM_TIMERS-1:0] lower_vec;
	logic [NUM_TIMERS-1:0] en_mask;
	logic [31:0]           status_word;
	logic [31:0]           rd;

	// Handshake
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_fire  = in_valid && in_ready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1  <= cmd;
			word_s1 <= word_index;
			data_s1 <= write_data;
			src_s1  <= tick_source;
		end
	end

	// Command decode
	always_comb begin
		is_read  = 1'b0;
		is_write = 1'b0;
		is_tick  = 1'b0;
		unique case (cmd_s1)
			gptb_pkg::CMD_READ:  is_read  = 1'b1;
			gptb_pkg::CMD_WRITE: is_write = 1'b1;
			gptb_pkg::CMD_TICK:  is_tick  = 1'b1;
			default: ;
		endcase
	end

	// Per-channel control, status clear bits and lower mask
	always_comb begin
		for (int t = 0; t < NUM_TIMERS; t++) begin
			ctl[t].tick        = adv && is_tick;
			ctl[t].src         = src_s1;
			ctl[t].wdata       = data_s1;
			ctl[t].cfg_we      = adv && is_write && (word_s1[5:2] == 4'(t))
				&& (word_s1[1:0] == gptb_pkg::REG_CONFIG);
			ctl[t].period_we   = adv && is_write && (word_s1[5:2] == 4'(t))
				&& (word_s1[1:0] == gptb_pkg::REG_PERIOD);
			ctl[t].width_we    = adv && is_write && (word_s1[5:2] == 4'(t))
				&& (word_s1[1:0] == gptb_pkg::REG_WIDTH);
			ctl[t].enable_set  = adv && is_write && (word_s1 == gptb_pkg::WORD_ENABLE)
				&& data_s1[t];
			ctl[t].disable_set = adv && is_write && (word_s1 == gptb_pkg::WORD_DISABLE)
				&& data_s1[t];
			ctl[t].halt        = adv && is_write && (word_s1 == gptb_pkg::WORD_STATUS)
				&& data_s1[(t >> 2) * gptb_pkg::STATUS_GROUP + (t & 3)
				+ gptb_pkg::STATUS_RUN];
			ctl[t].ovf_clr     = adv && is_write && (word_s1 == gptb_pkg::WORD_STATUS)
				&& data_s1[(t >> 2) * gptb_pkg::STATUS_GROUP + (t & 3)
				+ gptb_pkg::STATUS_OVF];
			ctl[t].pend_clr    = adv && is_write && (word_s1 == gptb_pkg::WORD_STATUS)
				&& data_s1[(t >> 2) * gptb_pkg::STATUS_GROUP + (t & 3)];
			lower_vec[t]       = is_write && (word_s1 == gptb_pkg::WORD_STATUS)
				&& data_s1[(t >> 2) * gptb_pkg::STATUS_GROUP + (t & 3)];
		end
	end

	// Timer channels
	for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_chan
		gptb_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[g]),
			.stat   (stat[g]),
			.raise  (raise_vec[g])
		);
	end

	// Enabled mask and status word
	always_comb begin
		status_word = '0;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			en_mask[t] = stat[t].enabled;
			status_word[(t >> 2) * gptb_pkg::STATUS_GROUP + (t & 3)] = stat[t].pending;
			status_word[(t >> 2) * gptb_pkg::STATUS_GROUP + (t & 3)
				+ gptb_pkg::STATUS_OVF] = stat[t].overflow;
			status_word[(t >> 2) * gptb_pkg::STATUS_GROUP + (t & 3)
				+ gptb_pkg::STATUS_RUN] = stat[t].running;
		end
	end

	// Read data mux
	always_comb begin
		rd = '0;
		if (is_read) begin
			priority if (!word_s1[5]) begin
				for (int t = 0; t < NUM_TIMERS; t++) begin
					if (word_s1[5:2] == 4'(t)) begin
						unique case (word_s1[1:0])
							gptb_pkg::REG_CONFIG: rd = {16'd0, stat[t].err, 6'd0, stat[t].cfg};
							gptb_pkg::REG_COUNT:  rd = stat[t].count;
							gptb_pkg::REG_PERIOD: rd = stat[t].period;
							gptb_pkg::REG_WIDTH:  rd = stat[t].width;
							default:              rd = '0;
						endcase
					end
				end
			end else if ((word_s1 == gptb_pkg::WORD_ENABLE)
				|| (word_s1 == gptb_pkg::WORD_DISABLE)) begin
				rd = 32'(en_mask);
			end else if (word_s1 == gptb_pkg::WORD_STATUS) begin
				rd = status_word;
			end else begin
				rd = '0;
			end
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_s2 <= rd;
			irq_raise_s2 <= 8'(raise_vec);
			irq_lower_s2 <= 8'(lower_vec);
		end
	end

	assign out_valid = valid_s2;
	assign read_data = read_data_s2;
	assign irq_raise = irq_raise_s2;
	assign irq_lower = irq_lower_s2;

endmodule

`default_nettype wire

// ===== rtl/gptb_chk.sv =====
// Port-level checker for the timer bank, bound to the top level.
`default_nettype none

module gptb_chk #(
	parameter int NUM_TIMERS = 8
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] read_data,
	input wire logic [7:0]  irq_raise,
	input wire logic [7:0]  irq_lower
);

	// Raise comes only from ticks, lower only from status writes
	a_raise_lower_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((irq_raise == 8'd0) || (irq_lower == 8'd0)))
		else $error("raise and lower in one transaction");

	// Read data only on reads, which carry no interrupt lines
	a_read_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (read_data != 32'd0)) |-> ((irq_raise == 8'd0) && (irq_lower == 8'd0)))
		else $error("interrupt lines on a read transaction");

	// No interrupt bits for absent timers
	a_absent_irq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((irq_raise | irq_lower) >> NUM_TIMERS) == 8'd0))
		else $error("interrupt bit for absent timer");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(read_data)
			&& $stable(irq_raise) && $stable(irq_lower)))
		else $error("stalled result changed");

	// An empty block takes an item
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !$past(in_valid && in_ready)) |-> in_ready)
		else $error("not ready while empty");

endmodule

bind general_purpose_timer_bank_core gptb_chk #(.NUM_TIMERS(NUM_TIMERS)) u_gptb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_data (read_data),
	.irq_raise (irq_raise),
	.irq_lower (irq_lower)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the timer bank core: directed and random bus and tick traffic.
module tb_top;

	localparam int NT = 8;
	localparam int RANDOM_ITEMS = 800;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [1:0] SRC_NONE = 2'd3;
	localparam logic [5:0] WORD_UNMAPPED = 6'd35;
	localparam logic [5:0] WORD_TOP = 6'd63;

	typedef struct packed {
		logic [31:0] rd;
		logic [7:0]  raise;
		logic [7:0]  lower;
	} bank_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = gptb_pkg::CMD_READ;
	logic [5:0]  word_index = '0;
	logic [31:0] write_data = '0;
	logic [1:0]  tick_source = gptb_pkg::SRC_SYSTEM;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_data;
	logic [7:0]  irq_raise;
	logic [7:0]  irq_lower;

	// Timer bank state as the testbench predicts it
	logic        tmr_enabled [NT];
	logic        tmr_running [NT];
	logic        tmr_overflow [NT];
	logic        tmr_pending [NT];
	logic [7:0]  tmr_cfg [NT];
	logic [1:0]  tmr_err [NT];
	logic [31:0] tmr_count [NT];
	logic [31:0] act_period [NT];
	logic [31:0] act_width [NT];
	logic [31:0] nxt_period [NT];
	logic [31:0] nxt_width [NT];
	logic [1:0]  tmr_src [NT];

	bank_result_t expected_results[$];
	int fail_count = 0;
	int burst_left = 0;
	int n_reads = 0, n_writes = 0, n_ticks = 0, n_other = 0;
	int n_raise = 0, n_lower = 0;
	int rx_mode = 0, rx_left = 0;

	general_purpose_timer_bank_core #(.NUM_TIMERS(NT)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.word_index(word_index),
		.write_data(write_data),
		.tick_source(tick_source),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.irq_raise(irq_raise),
		.irq_lower(irq_lower)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Stop the timer and make the buffered period and width active
	function automatic void stop_and_load(int t);
		tmr_running[t] = 1'b0;
		act_period[t] = nxt_period[t];
		act_width[t] = nxt_width[t];
	endfunction

	// Apply one transaction to the predicted state and return the expected result
	function automatic bank_result_t predict_item(logic [1:0] op, logic [5:0] w,
			logic [31:0] d, logic [1:0] s);
		bank_result_t r;
		int t;
		int sh;
		logic irq_en;
		r = '0;
		t = w[4:2];
		case (op)
		gptb_pkg::CMD_READ: begin
			if (w < 6'd32) begin
				case (w[1:0])
				gptb_pkg::REG_CONFIG: r.rd = {16'd0, tmr_err[t], 6'd0, tmr_cfg[t]};
				gptb_pkg::REG_COUNT:  r.rd = tmr_count[t];
				gptb_pkg::REG_PERIOD: r.rd = act_period[t];
				default:              r.rd = act_width[t];
				endcase
			end else if (w == gptb_pkg::WORD_ENABLE || w == gptb_pkg::WORD_DISABLE) begin
				for (int i = 0; i < NT; i++)
					r.rd[i] = tmr_enabled[i];
			end else if (w == gptb_pkg::WORD_STATUS) begin
				for (int i = 0; i < NT; i++) begin
					sh = (i / 4) * gptb_pkg::STATUS_GROUP + (i % 4);
					r.rd[sh + gptb_pkg::STATUS_RUN] = tmr_running[i];
					r.rd[sh + gptb_pkg::STATUS_OVF] = tmr_overflow[i];
					r.rd[sh] = tmr_pending[i];
				end
			end
		end
		gptb_pkg::CMD_WRITE: begin
			if (w < 6'd32) begin
				case (w[1:0])
				gptb_pkg::REG_CONFIG: tmr_cfg[t] = d[7:0] & gptb_pkg::CFG_WRITABLE;
				gptb_pkg::REG_PERIOD: nxt_period[t] = d;
				gptb_pkg::REG_WIDTH:  nxt_width[t] = d;
				default: ;
				endcase
			end else begin
				for (int i = 0; i < NT; i++) begin
					if (w == gptb_pkg::WORD_ENABLE && d[i]) begin
						// start only on a rising enable
						if (!tmr_enabled[i]) begin
							tmr_count[i] = tmr_cfg[i][gptb_pkg::CFG_CLK_SEL] ? 32'd0 : 32'd1;
							if (!tmr_cfg[i][gptb_pkg::CFG_CLK_SEL])
								tmr_src[i] = gptb_pkg::SRC_SYSTEM;
							else if (!tmr_cfg[i][gptb_pkg::CFG_TIN_SEL])
								tmr_src[i] = gptb_pkg::SRC_PIN;
							else
								tmr_src[i] = gptb_pkg::SRC_TIMER;
							stop_and_load(i);
							tmr_running[i] = 1'b1;
						end
						tmr_enabled[i] = 1'b1;
					end else if (w == gptb_pkg::WORD_DISABLE && d[i]) begin
						tmr_enabled[i] = 1'b0;
					end else if (w == gptb_pkg::WORD_STATUS) begin
						sh = (i / 4) * gptb_pkg::STATUS_GROUP + (i % 4);
						if (d[sh + gptb_pkg::STATUS_RUN])
							stop_and_load(i);
						if (d[sh + gptb_pkg::STATUS_OVF]) begin
							tmr_overflow[i] = 1'b0;
							tmr_err[i] = gptb_pkg::ERR_NONE;
						end
						if (d[sh]) begin
							tmr_pending[i] = 1'b0;
							r.lower[i] = 1'b1;
						end
					end
				end
			end
		end
		gptb_pkg::CMD_TICK: begin
			for (int i = 0; i < NT; i++) begin
				if (tmr_running[i] && tmr_src[i] == s) begin
					irq_en = tmr_cfg[i][gptb_pkg::CFG_IRQ_ENA];
					tmr_count[i] = tmr_count[i] + 32'd1;
					if (tmr_count[i] == gptb_pkg::ALL_ONES) begin
						tmr_overflow[i] = 1'b1;
						tmr_err[i] = gptb_pkg::ERR_OVERFLOW;
						if (irq_en)
							r.raise[i] = 1'b1;
					end
					if (tmr_cfg[i][gptb_pkg::CFG_PERIOD_CNT] &&
							tmr_count[i] == act_period[i]) begin
						// period match: reload, keep going while enabled
						tmr_pending[i] = 1'b1;
						if (irq_en)
							r.raise[i] = 1'b1;
						stop_and_load(i);
						if (tmr_enabled[i]) begin
							tmr_count[i] = 32'd0;
							tmr_running[i] = 1'b1;
						end
					end else if (!tmr_cfg[i][gptb_pkg::CFG_PERIOD_CNT] &&
							tmr_count[i] == act_width[i]) begin
						// width match: one shot, disables itself
						tmr_pending[i] = 1'b1;
						if (irq_en)
							r.raise[i] = 1'b1;
						tmr_enabled[i] = 1'b0;
						stop_and_load(i);
					end
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] reg_word(int t, logic [1:0] r);
		return {t[2:0], r};
	endfunction

	// Mostly short counts so matches happen often; now and then a full-range value
	function automatic logic [31:0] small_count();
		if ($urandom_range(0, 15) == 0)
			return $urandom;
		return $urandom_range(0, 10);
	endfunction

	// Send one transaction; the sender idles between bursts
	task automatic send_item(input logic [1:0] op, input logic [5:0] w,
			input logic [31:0] d, input logic [1:0] s);
		bank_result_t r;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		cmd <= op;
		word_index <= w;
		write_data <= d;
		tick_source <= s;
		do @(posedge clk); while (!in_ready);
		r = predict_item(op, w, d, s);
		expected_results.push_back(r);
		burst_left--;
		case (op)
		gptb_pkg::CMD_READ:  n_reads++;
		gptb_pkg::CMD_WRITE: n_writes++;
		gptb_pkg::CMD_TICK:  n_ticks++;
		default:             n_other++;
		endcase
		if (r.raise != 8'd0)
			n_raise++;
		if (r.lower != 8'd0)
			n_lower++;
	endtask

	// Hold off the sender until every outstanding result is back
	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		burst_left = 0;
	endtask

	// Receiver stall pattern: changes mode when its random countdown runs out
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(16, 160);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
		0:       out_ready <= 1'b1;
		1:       out_ready <= ($urandom_range(0, 1) == 1);
		2:       out_ready <= ($urandom_range(0, 3) == 0);
		default: out_ready <= (rx_left[1:0] == 2'b00);
		endcase
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		bank_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: read_data %h irq_raise %h irq_lower %h",
					$time, read_data, irq_raise, irq_lower);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (read_data !== want.rd) begin
					$display("%0t: read_data mismatch: expected %h, got %h",
						$time, want.rd, read_data);
					fail_count++;
				end
				if (irq_raise !== want.raise) begin
					$display("%0t: irq_raise mismatch: expected %h, got %h",
						$time, want.raise, irq_raise);
					fail_count++;
				end
				if (irq_lower !== want.lower) begin
					$display("%0t: irq_lower mismatch: expected %h, got %h",
						$time, want.lower, irq_lower);
					fail_count++;
				end
			end
		end
	end

	// Reset values, unmapped word, unknown command
	task automatic test_reset_values();
		send_item(gptb_pkg::CMD_READ, gptb_pkg::WORD_STATUS, gptb_pkg::ALL_ONES, SRC_NONE);
		send_item(gptb_pkg::CMD_READ, reg_word(0, gptb_pkg::REG_COUNT), 32'd0,
			gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_READ, WORD_TOP, 32'd0, gptb_pkg::SRC_SYSTEM);
		send_item(CMD_NONE, gptb_pkg::WORD_STATUS, gptb_pkg::ALL_ONES, SRC_NONE);
	endtask

	// Timer 0 in period mode on the timer clock; all timers started at once
	task automatic test_period_mode();
		send_item(gptb_pkg::CMD_WRITE, reg_word(0, gptb_pkg::REG_CONFIG), gptb_pkg::ALL_ONES,
			gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_READ, reg_word(0, gptb_pkg::REG_CONFIG), 32'd0,
			gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_WRITE, reg_word(0, gptb_pkg::REG_PERIOD), 32'd2,
			gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_WRITE, reg_word(0, gptb_pkg::REG_COUNT), 32'h1234_5678,
			gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_WRITE, gptb_pkg::WORD_ENABLE, gptb_pkg::ALL_ONES,
			gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_TICK, 6'd0, 32'd0, gptb_pkg::SRC_TIMER);
		send_item(gptb_pkg::CMD_TICK, 6'd0, 32'd0, gptb_pkg::SRC_TIMER);
		send_item(gptb_pkg::CMD_TICK, 6'd0, 32'd0, SRC_NONE);
		send_item(gptb_pkg::CMD_READ, gptb_pkg::WORD_STATUS, 32'd0, gptb_pkg::SRC_SYSTEM);
	endtask

	// Status clear of everything, then timer 5 as a one-shot on the system clock
	task automatic test_width_mode();
		send_item(gptb_pkg::CMD_WRITE, gptb_pkg::WORD_STATUS, gptb_pkg::ALL_ONES,
			gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_WRITE, reg_word(5, gptb_pkg::REG_CONFIG),
			32'd1 << gptb_pkg::CFG_IRQ_ENA, gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_WRITE, reg_word(5, gptb_pkg::REG_WIDTH), 32'd2,
			gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_WRITE, gptb_pkg::WORD_DISABLE, gptb_pkg::ALL_ONES,
			gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_WRITE, gptb_pkg::WORD_ENABLE, 32'd1 << 5, gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_TICK, 6'd0, 32'd0, gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_READ, gptb_pkg::WORD_ENABLE, 32'd0, gptb_pkg::SRC_SYSTEM);
		send_item(gptb_pkg::CMD_READ, gptb_pkg::WORD_DISABLE, 32'd0, gptb_pkg::SRC_SYSTEM);
	endtask

	// Full-range buffer values, empty status write, unmapped write
	task automatic test_extremes();
		send_item(gptb_pkg::CMD_WRITE, reg_word(7, gptb_pkg::REG_PERIOD), gptb_pkg::ALL_ONES,
			gptb_pkg::SRC_PIN);
		send_item(gptb_pkg::CMD_WRITE, reg_word(7, gptb_pkg::REG_WIDTH), gptb_pkg::ALL_ONES,
			gptb_pkg::SRC_PIN);
		send_item(gptb_pkg::CMD_WRITE, gptb_pkg::WORD_STATUS, 32'd0, gptb_pkg::SRC_PIN);
		send_item(gptb_pkg::CMD_WRITE, WORD_UNMAPPED, gptb_pkg::ALL_ONES, gptb_pkg::SRC_PIN);
		send_item(gptb_pkg::CMD_READ, reg_word(7, gptb_pkg::REG_PERIOD), 32'd0,
			gptb_pkg::SRC_PIN);
	endtask

	// Program one timer and clock it, with reads and interfering writes mixed in
	task automatic run_timer_program();
		int t;
		logic [7:0] cfg;
		logic [1:0] src;
		t = $urandom_range(0, NT - 1);
		cfg = 8'($urandom);
		cfg[gptb_pkg::CFG_IRQ_ENA] = ($urandom_range(0, 3) != 0);
		if (!cfg[gptb_pkg::CFG_CLK_SEL])
			src = gptb_pkg::SRC_SYSTEM;
		else if (!cfg[gptb_pkg::CFG_TIN_SEL])
			src = gptb_pkg::SRC_PIN;
		else
			src = gptb_pkg::SRC_TIMER;
		send_item(gptb_pkg::CMD_WRITE, gptb_pkg::WORD_DISABLE, 32'd1 << t,
			2'($urandom_range(0, 3)));
		send_item(gptb_pkg::CMD_WRITE, reg_word(t, gptb_pkg::REG_CONFIG),
			($urandom & 32'hFFFF_FF00) | {24'd0, cfg}, 2'($urandom_range(0, 3)));
		send_item(gptb_pkg::CMD_WRITE, reg_word(t, gptb_pkg::REG_PERIOD), small_count(),
			2'($urandom_range(0, 3)));
		send_item(gptb_pkg::CMD_WRITE, reg_word(t, gptb_pkg::REG_WIDTH), small_count(),
			2'($urandom_range(0, 3)));
		send_item(gptb_pkg::CMD_WRITE, gptb_pkg::WORD_ENABLE,
			$urandom_range(0, 1) ? (32'd1 << t) : ($urandom | (32'd1 << t)),
			2'($urandom_range(0, 3)));
		repeat ($urandom_range(4, 24)) begin
			case ($urandom_range(0, 11))
			0: send_item(gptb_pkg::CMD_READ, gptb_pkg::WORD_STATUS, $urandom,
				2'($urandom_range(0, 3)));
			1: send_item(gptb_pkg::CMD_READ, reg_word(t, 2'($urandom_range(0, 3))), $urandom,
				2'($urandom_range(0, 3)));
			2: send_item(gptb_pkg::CMD_WRITE, gptb_pkg::WORD_STATUS, $urandom & $urandom,
				2'($urandom_range(0, 3)));
			3: send_item(gptb_pkg::CMD_WRITE,
				reg_word(t, $urandom_range(0, 1) ? gptb_pkg::REG_PERIOD : gptb_pkg::REG_WIDTH),
				small_count(), 2'($urandom_range(0, 3)));
			4: send_item(gptb_pkg::CMD_WRITE, gptb_pkg::WORD_DISABLE, 32'd1 << t,
				2'($urandom_range(0, 3)));
			5: send_item(gptb_pkg::CMD_TICK, 6'($urandom_range(0, 63)), $urandom,
				2'($urandom_range(0, 3)));
			default: send_item(gptb_pkg::CMD_TICK, 6'($urandom_range(0, 63)), $urandom, src);
			endcase
		end
	endtask

	// Unstructured transaction, any command and any word
	task automatic send_noise_item();
		logic [5:0] w;
		w = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 35))
			: 6'($urandom_range(0, 63));
		send_item(2'($urandom_range(0, 3)), w, $urandom, 2'($urandom_range(0, 3)));
	endtask

	task automatic test_random_traffic();
		int start;
		int seq_n;
		start = n_reads + n_writes + n_ticks + n_other;
		seq_n = 0;
		while (n_reads + n_writes + n_ticks + n_other - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0)
				run_timer_program();
			else
				repeat ($urandom_range(1, 4)) send_noise_item();
			seq_n++;
			if (seq_n % 20 == 0)
				wait_all_results();
		end
	endtask

	initial begin
		for (int i = 0; i < NT; i++) begin
			tmr_enabled[i] = 1'b0;
			tmr_running[i] = 1'b0;
			tmr_overflow[i] = 1'b0;
			tmr_pending[i] = 1'b0;
			tmr_cfg[i] = 8'd0;
			tmr_err[i] = gptb_pkg::ERR_NONE;
			tmr_count[i] = 32'd1;
			act_period[i] = 32'd0;
			act_width[i] = 32'd0;
			nxt_period[i] = 32'd0;
			nxt_width[i] = 32'd0;
			tmr_src[i] = gptb_pkg::SRC_SYSTEM;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_period_mode();
		test_width_mode();
		test_extremes();
		wait_all_results();
		test_random_traffic();

		wait_all_results();
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			fail_count++;
		end
		$display("Ran %0d transactions: %0d reads, %0d writes, %0d ticks, %0d unknown commands",
			n_reads + n_writes + n_ticks + n_other, n_reads, n_writes, n_ticks, n_other);
		$display("Interrupts: %0d transactions raised lines, %0d lowered lines",
			n_raise, n_lower);
		if (fail_count == 0)
			$display("general_purpose_timer_bank_core test passed");
		else
			$display("general_purpose_timer_bank_core test failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("%0t: timeout", $time);
		$display("general_purpose_timer_bank_core test failed");
		$finish;
	end

endmodule
